// ===== design/ddm_pkg.sv =====
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared types and constants for the doubly linked deque manager.
// ----------------------------------------------------------------------------
`default_nettype none

package ddm_pkg;

  localparam int unsigned NodeCountDef = 16;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned NodeWidth   = 4;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 16;

  typedef enum logic [OpWidth-1:0] {
    OP_INS_HEAD  = 3'd0,
    OP_INS_TAIL  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_REAR  = 3'd3,
    OP_REM_NAMED = 3'd4
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INS_FIRST,
    CMD_INS_HEAD_A,
    CMD_INS_HEAD_B,
    CMD_INS_TAIL_A,
    CMD_INS_TAIL_B,
    CMD_RD_FRONT,
    CMD_RD_REAR,
    CMD_RD_NAMED,
    CMD_TAKE_FRONT,
    CMD_TAKE_REAR,
    CMD_TAKE_NAMED,
    CMD_OUT
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LINK,
    S_TAKE,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e    op;
    status_e status;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OpWidth-1:0] op;
    logic               empty;
    logic               node_ok;
    logic               node_in;
    logic               node_head;
    logic               node_tail;
    logic               out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/ddm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddm_ctrl
// Request sequencer: decodes each request and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_ctrl
  import ddm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire dp_stat_t stat_i,
  output ctl_cmd_t      cmd_o
);

  state_e  state_q, state_d;
  status_e status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    req_ready_o   = 1'b0;
    cmd_o.op      = CMD_NONE;
    cmd_o.status  = status_q;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        unique case (stat_i.op) inside
          OP_INS_HEAD, OP_INS_TAIL: begin
            if (!stat_i.node_ok || stat_i.node_in) begin
              status_d = ST_INVALID;
            end else begin
              status_d = ST_OK;
              if (stat_i.empty) begin
                cmd_o.op = CMD_INS_FIRST;
              end else begin
                cmd_o.op = (stat_i.op == OP_INS_HEAD) ? CMD_INS_HEAD_A : CMD_INS_TAIL_A;
                state_d  = S_LINK;
              end
            end
          end
          OP_REM_FRONT, OP_REM_REAR: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else begin
              status_d = ST_OK;
              cmd_o.op = (stat_i.op == OP_REM_FRONT) ? CMD_RD_FRONT : CMD_RD_REAR;
              state_d  = S_TAKE;
            end
          end
          OP_REM_NAMED: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else if (!stat_i.node_ok || !stat_i.node_in) begin
              status_d = ST_INVALID;
            end else begin
              status_d = ST_OK;
              state_d  = S_TAKE;
              if (stat_i.node_head) begin
                cmd_o.op = CMD_RD_FRONT;
              end else if (stat_i.node_tail) begin
                cmd_o.op = CMD_RD_REAR;
              end else begin
                cmd_o.op = CMD_RD_NAMED;
              end
            end
          end
          default: begin
            status_d = ST_INVALID;
          end
        endcase
      end
      S_LINK: begin
        cmd_o.op = (stat_i.op == OP_INS_HEAD) ? CMD_INS_HEAD_B : CMD_INS_TAIL_B;
        state_d  = S_DONE;
      end
      S_TAKE: begin
        state_d = S_DONE;
        if (stat_i.op == OP_REM_FRONT ||
            (stat_i.op == OP_REM_NAMED && stat_i.node_head)) begin
          cmd_o.op = CMD_TAKE_FRONT;
        end else if (stat_i.op == OP_REM_REAR ||
                     (stat_i.op == OP_REM_NAMED && stat_i.node_tail)) begin
          cmd_o.op = CMD_TAKE_REAR;
        end else begin
          cmd_o.op = CMD_TAKE_NAMED;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = CMD_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ddm_datapath.sv =====
// ----------------------------------------------------------------------------
// ddm_datapath
// Head, tail, count, membership bits, link memories and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_datapath
  import ddm_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NodeCountDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ctl_cmd_t               cmd_i,
  input  wire logic [OpWidth-1:0]     in_op_i,
  input  wire logic [NodeWidth-1:0]   in_node_i,
  output dp_stat_t                    stat_o,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic [NodeWidth-1:0]        removed_node_o,
  output logic                        removed_valid_o,
  output logic [CountWidth-1:0]       entry_count_o,
  output logic [StatusWidth-1:0]      status_o
);

  localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned LW = $clog2(NODE_COUNT + 1);
  localparam logic [LW-1:0] NoneLink = LW'(NODE_COUNT);

  logic [OpWidth-1:0]   req_op_q;
  logic [NodeWidth-1:0] req_node_q;
  logic [LW-1:0]        head_q, head_d;
  logic [LW-1:0]        tail_q, tail_d;
  logic [LW-1:0]        count_q, count_d;
  logic [NODE_COUNT-1:0] in_list_q, in_list_d;
  logic [LW-1:0]        gone_q, gone_d;
  logic                 got_q, got_d;

  logic [LW-1:0] next_mem [NODE_COUNT];
  logic [LW-1:0] prev_mem [NODE_COUNT];
  logic [LW-1:0] rd_next_q, rd_prev_q;
  logic [AW-1:0] rd_next_addr, rd_prev_addr;
  logic          nw_en, pw_en;
  logic [AW-1:0] nw_addr, pw_addr;
  logic [LW-1:0] nw_data, pw_data;

  logic                   out_valid_q;
  logic [NodeWidth-1:0]   out_node_q;
  logic                   out_got_q;
  logic [CountWidth-1:0]  out_count_q;
  logic [StatusWidth-1:0] out_status_q;

  logic [AW-1:0] n_idx, head_idx, tail_idx;
  logic [LW-1:0] n_link;
  logic          node_ok;

  assign n_idx    = AW'(req_node_q);
  assign n_link   = LW'(n_idx);
  assign head_idx = head_q[AW-1:0];
  assign tail_idx = tail_q[AW-1:0];
  assign node_ok  = 32'(req_node_q) < 32'(NODE_COUNT);

  assign stat_o.op        = req_op_q;
  assign stat_o.empty     = (head_q == NoneLink) || (tail_q == NoneLink);
  assign stat_o.node_ok   = node_ok;
  assign stat_o.node_in   = node_ok && in_list_q[n_idx];
  assign stat_o.node_head = n_link == head_q;
  assign stat_o.node_tail = n_link == tail_q;
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign rd_next_addr = (cmd_i.op == CMD_RD_FRONT) ? head_idx : n_idx;
  assign rd_prev_addr = (cmd_i.op == CMD_RD_REAR) ? tail_idx : n_idx;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    in_list_d = in_list_q;
    gone_d    = gone_q;
    got_d     = got_q;
    nw_en     = 1'b0;
    pw_en     = 1'b0;
    nw_addr   = n_idx;
    pw_addr   = n_idx;
    nw_data   = NoneLink;
    pw_data   = NoneLink;
    unique case (cmd_i.op)
      CMD_LOAD: begin
        gone_d = '0;
        got_d  = 1'b0;
      end
      CMD_INS_FIRST: begin
        nw_en            = 1'b1;
        pw_en            = 1'b1;
        head_d           = n_link;
        tail_d           = n_link;
        in_list_d[n_idx] = 1'b1;
        count_d          = count_q + 1'b1;
      end
      CMD_INS_HEAD_A: begin
        nw_en            = 1'b1;
        nw_data          = head_q;
        pw_en            = 1'b1;
        in_list_d[n_idx] = 1'b1;
        count_d          = count_q + 1'b1;
      end
      CMD_INS_HEAD_B: begin
        pw_en   = 1'b1;
        pw_addr = head_idx;
        pw_data = n_link;
        head_d  = n_link;
      end
      CMD_INS_TAIL_A: begin
        pw_en            = 1'b1;
        pw_data          = tail_q;
        nw_en            = 1'b1;
        in_list_d[n_idx] = 1'b1;
        count_d          = count_q + 1'b1;
      end
      CMD_INS_TAIL_B: begin
        nw_en   = 1'b1;
        nw_addr = tail_idx;
        nw_data = n_link;
        tail_d  = n_link;
      end
      CMD_TAKE_FRONT: begin
        if (rd_next_q != NoneLink) begin
          pw_en   = 1'b1;
          pw_addr = rd_next_q[AW-1:0];
          head_d  = rd_next_q;
        end else begin
          head_d = NoneLink;
          tail_d = NoneLink;
        end
        in_list_d[head_idx] = 1'b0;
        count_d             = count_q - 1'b1;
        gone_d              = head_q;
        got_d               = 1'b1;
      end
      CMD_TAKE_REAR: begin
        if (rd_prev_q != NoneLink) begin
          nw_en   = 1'b1;
          nw_addr = rd_prev_q[AW-1:0];
          tail_d  = rd_prev_q;
        end else begin
          head_d = NoneLink;
          tail_d = NoneLink;
        end
        in_list_d[tail_idx] = 1'b0;
        count_d             = count_q - 1'b1;
        gone_d              = tail_q;
        got_d               = 1'b1;
      end
      CMD_TAKE_NAMED: begin
        nw_en            = 1'b1;
        nw_addr          = rd_prev_q[AW-1:0];
        nw_data          = rd_next_q;
        pw_en            = 1'b1;
        pw_addr          = rd_next_q[AW-1:0];
        pw_data          = rd_prev_q;
        in_list_d[n_idx] = 1'b0;
        count_d          = count_q - 1'b1;
        gone_d           = n_link;
        got_d            = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    rd_next_q <= next_mem[rd_next_addr];
    rd_prev_q <= prev_mem[rd_prev_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= NoneLink;
      tail_q    <= NoneLink;
      count_q   <= '0;
      in_list_q <= '0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      in_list_q <= in_list_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_LOAD) begin
      req_op_q   <= in_op_i;
      req_node_q <= in_node_i;
    end
    gone_q <= gone_d;
    got_q  <= got_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == CMD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_OUT) begin
      out_node_q   <= NodeWidth'(gone_q);
      out_got_q    <= got_q;
      out_count_q  <= CountWidth'(count_q);
      out_status_q <= cmd_i.status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_node_o  = out_node_q;
  assign removed_valid_o = out_got_q;
  assign entry_count_o   = out_count_q;
  assign status_o        = out_status_q;

  a_head_tail_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NoneLink) == (tail_q == NoneLink))
    else $error("head and tail disagree on empty list");

  a_count_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (head_q == NoneLink))
    else $error("count disagrees with head");

  a_count_members: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_list_q) == int'(count_q))
    else $error("count disagrees with membership bits");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == CMD_OUT |=> out_valid_q)
    else $error("result not presented after load");

endmodule

`default_nettype wire

// ===== design/doubly_linked_deque_manager.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_deque_manager
// Deque of node indices kept as a doubly linked list over a fixed node pool.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (op and node in tdata); each request
// yields exactly one result on the m_axis channel (removed node, removed
// flag, entry count and status in tdata).
// A request is taken in the idle state and decoded in the decode state.
// Inserts into a non-empty list and removals that take a node out pass
// through a link or take state; inserts into an empty list and rejected
// requests go straight on. The done state loads the result into the output
// register. The link memories have one write port each and a registered
// read, which sets the extra step of each removal and of a linking insert.
// A new request is taken while the previous result still waits in the
// output register; if the receiver stalls, the next result holds in the
// done state until the register frees. Reset clears the list (no head, no
// tail, count zero, no members); the link memories need no clearing, since
// links are read only for members and every insert writes both links of the new node.
// ----------------------------------------------------------------------------
`default_nettype none

module doubly_linked_deque_manager
  import ddm_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NodeCountDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,   // op[2:0], node[6:3]
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OutDataWidth-1:0]      m_axis_tdata    // removed_node[3:0],
                                                       // removed_valid[4],
                                                       // entry_count[9:5],
                                                       // status[11:10]
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  logic [NodeWidth-1:0]   removed_node;
  logic                   removed_valid;
  logic [CountWidth-1:0]  entry_count;
  logic [StatusWidth-1:0] status;

  ddm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ddm_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_op_i         (s_axis_tdata[2:0]),
    .in_node_i       (s_axis_tdata[6:3]),
    .stat_o          (stat),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .removed_node_o  (removed_node),
    .removed_valid_o (removed_valid),
    .entry_count_o   (entry_count),
    .status_o        (status)
  );

  assign m_axis_tdata = {4'd0, status, entry_count, removed_valid, removed_node};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the doubly linked deque manager.
// ----------------------------------------------------------------------------
// A short table of hand-picked requests opens the run: removals from the
// empty list, reserved op codes, duplicate inserts, and named removals of
// head, tail, middle and absent nodes. Rows with an obvious answer carry it
// typed in; the rest go through a local model of the list. Bursts of
// fill-heavy, drain-heavy and mixed random requests follow. Both sides stall
// at random, except for one calm stretch. Every result is compared field by
// field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ddm_pkg::*;

  localparam int unsigned NODES = NodeCountDef;
  localparam logic [CountWidth-1:0] NO_LINK = CountWidth'(NodeCountDef);
  localparam logic [OpWidth-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OpWidth-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [OpWidth-1:0] OP_RSVD_HI = 3'd7;
  localparam int unsigned RANDOM_REQUESTS = 600;
  localparam int unsigned BURST_LEN = 40;
  localparam int unsigned CALM_FIRST = 200;
  localparam int unsigned CALM_LAST = 320;
  localparam int unsigned DRAIN_AT = 400;
  localparam int unsigned STALL_PCT = 32;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PLAN_ROWS = 25;

  typedef struct packed {
    logic [NodeWidth-1:0]  node;
    logic                  valid;
    logic [CountWidth-1:0] count;
    status_e               status;
  } result_t;

  typedef struct {
    logic [OpWidth-1:0]   op;
    logic [NodeWidth-1:0] node;
    bit                   typed;
    result_t              want;
  } plan_row_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;   // op[2:0], node[6:3], zero[7]
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;   // removed_node[3:0], removed_valid[4],
                                           // entry_count[9:5], status[11:10]

  logic [CountWidth-1:0] dq_head;
  logic [CountWidth-1:0] dq_tail;
  logic [CountWidth-1:0] dq_count;
  logic [CountWidth-1:0] dq_next [NODES];
  logic [CountWidth-1:0] dq_prev [NODES];
  logic                  dq_member [NODES];

  result_t     pending_results [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          calm;

  plan_row_t plan [PLAN_ROWS] = '{
    '{OP_REM_FRONT, 4'd0,  1'b1, '{4'd0, 1'b0, 5'd0, ST_EMPTY}},
    '{OP_REM_REAR,  4'd0,  1'b1, '{4'd0, 1'b0, 5'd0, ST_EMPTY}},
    '{OP_REM_NAMED, 4'd15, 1'b1, '{4'd0, 1'b0, 5'd0, ST_EMPTY}},
    '{OP_RSVD_LO,   4'd0,  1'b1, '{4'd0, 1'b0, 5'd0, ST_INVALID}},
    '{OP_RSVD_HI,   4'd15, 1'b1, '{4'd0, 1'b0, 5'd0, ST_INVALID}},
    '{OP_INS_HEAD,  4'd0,  1'b1, '{4'd0, 1'b0, 5'd1, ST_OK}},
    '{OP_INS_HEAD,  4'd0,  1'b1, '{4'd0, 1'b0, 5'd1, ST_INVALID}},
    '{OP_INS_TAIL,  4'd15, 1'b1, '{4'd0, 1'b0, 5'd2, ST_OK}},
    '{OP_INS_HEAD,  4'd5,  1'b0, '0},
    '{OP_INS_TAIL,  4'd10, 1'b0, '0},
    '{OP_REM_NAMED, 4'd3,  1'b1, '{4'd0, 1'b0, 5'd4, ST_INVALID}},
    '{OP_INS_TAIL,  4'd15, 1'b1, '{4'd0, 1'b0, 5'd4, ST_INVALID}},
    '{OP_REM_NAMED, 4'd0,  1'b0, '0},
    '{OP_REM_NAMED, 4'd5,  1'b0, '0},
    '{OP_REM_NAMED, 4'd10, 1'b0, '0},
    '{OP_INS_TAIL,  4'd7,  1'b0, '0},
    '{OP_INS_HEAD,  4'd9,  1'b0, '0},
    '{OP_REM_REAR,  4'd0,  1'b0, '0},
    '{OP_REM_FRONT, 4'd0,  1'b0, '0},
    '{OP_REM_REAR,  4'd0,  1'b0, '0},
    '{OP_INS_TAIL,  4'd6,  1'b0, '0},
    '{OP_RSVD_MID,  4'd6,  1'b1, '{4'd0, 1'b0, 5'd1, ST_INVALID}},
    '{OP_REM_NAMED, 4'd6,  1'b0, '0},
    '{OP_REM_NAMED, 4'd6,  1'b1, '{4'd0, 1'b0, 5'd0, ST_EMPTY}},
    '{OP_INS_HEAD,  4'd12, 1'b1, '{4'd0, 1'b0, 5'd1, ST_OK}}
  };

  doubly_linked_deque_manager u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void release_node(logic [NodeWidth-1:0] n);
    dq_next[n] = NO_LINK;
    dq_prev[n] = NO_LINK;
    dq_member[n] = 1'b0;
    if (dq_count != 0) dq_count--;
  endfunction

  function automatic logic [NodeWidth-1:0] pop_head();
    logic [CountWidth-1:0] h;
    logic [CountWidth-1:0] nx;
    h = dq_head;
    nx = dq_next[h[NodeWidth-1:0]];
    if (!nx[NodeWidth]) begin
      dq_prev[nx[NodeWidth-1:0]] = NO_LINK;
      dq_head = nx;
    end else begin
      dq_head = NO_LINK;
      dq_tail = NO_LINK;
    end
    release_node(h[NodeWidth-1:0]);
    return h[NodeWidth-1:0];
  endfunction

  function automatic logic [NodeWidth-1:0] pop_tail();
    logic [CountWidth-1:0] t;
    logic [CountWidth-1:0] pv;
    t = dq_tail;
    pv = dq_prev[t[NodeWidth-1:0]];
    if (!pv[NodeWidth]) begin
      dq_next[pv[NodeWidth-1:0]] = NO_LINK;
      dq_tail = pv;
    end else begin
      dq_head = NO_LINK;
      dq_tail = NO_LINK;
    end
    release_node(t[NodeWidth-1:0]);
    return t[NodeWidth-1:0];
  endfunction

  function automatic void link_node(logic [NodeWidth-1:0] n, bit at_head);
    if (dq_head[NodeWidth] || dq_tail[NodeWidth]) begin
      dq_next[n] = NO_LINK;
      dq_prev[n] = NO_LINK;
      dq_head = {1'b0, n};
      dq_tail = {1'b0, n};
    end else if (at_head) begin
      dq_next[n] = dq_head;
      dq_prev[n] = NO_LINK;
      dq_prev[dq_head[NodeWidth-1:0]] = {1'b0, n};
      dq_head = {1'b0, n};
    end else begin
      dq_prev[n] = dq_tail;
      dq_next[n] = NO_LINK;
      dq_next[dq_tail[NodeWidth-1:0]] = {1'b0, n};
      dq_tail = {1'b0, n};
    end
    dq_member[n] = 1'b1;
    dq_count++;
  endfunction

  function automatic result_t apply_request(logic [OpWidth-1:0] op,
                                            logic [NodeWidth-1:0] node);
    result_t r;
    bit empty;
    logic [CountWidth-1:0] pv;
    logic [CountWidth-1:0] nx;
    r = '{node: '0, valid: 1'b0, count: '0, status: ST_OK};
    empty = dq_head[NodeWidth] || dq_tail[NodeWidth];
    case (op)
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (dq_member[node]) r.status = ST_INVALID;
        else link_node(node, op == OP_INS_HEAD);
      end
      OP_REM_FRONT, OP_REM_REAR: begin
        if (empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.node = (op == OP_REM_FRONT) ? pop_head() : pop_tail();
          r.valid = 1'b1;
        end
      end
      OP_REM_NAMED: begin
        if (empty) begin
          r.status = ST_EMPTY;
        end else if (!dq_member[node]) begin
          r.status = ST_INVALID;
        end else if ({1'b0, node} == dq_head) begin
          r.node = pop_head();
          r.valid = 1'b1;
        end else if ({1'b0, node} == dq_tail) begin
          r.node = pop_tail();
          r.valid = 1'b1;
        end else begin
          pv = dq_prev[node];
          nx = dq_next[node];
          if (!pv[NodeWidth]) dq_next[pv[NodeWidth-1:0]] = nx;
          if (!nx[NodeWidth]) dq_prev[nx[NodeWidth-1:0]] = pv;
          release_node(node);
          r.node = node;
          r.valid = 1'b1;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    r.count = dq_count;
    return r;
  endfunction

  function automatic logic [NodeWidth-1:0] pick_node(bit want_member);
    logic [NodeWidth-1:0] start;
    logic [NodeWidth-1:0] idx;
    start = NodeWidth'($urandom_range(0, NODES - 1));
    for (int k = 0; k < NODES; k++) begin
      idx = start + NodeWidth'(k);
      if (dq_member[idx] == want_member) return idx;
    end
    return start;
  endfunction

  task automatic send_request(input logic [OpWidth-1:0] op, input logic [NodeWidth-1:0] node,
                              input bit typed, input result_t want);
    result_t predicted;
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, node, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = apply_request(op, node);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.node = m_axis_tdata[3:0];
      got.valid = m_axis_tdata[4];
      got.count = m_axis_tdata[9:5];
      got.status = status_e'(m_axis_tdata[11:10]);
      if (pending_results.size() == 0) begin
        $error("result with no request pending: tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.node !== want.node) begin
          $error("removed_node: expected %0d, actual %0d", want.node, got.node);
          error_count++;
        end
        if (got.valid !== want.valid) begin
          $error("removed_valid: expected %0d, actual %0d", want.valid, got.valid);
          error_count++;
        end
        if (got.count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, got.count);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    mix_e mode;
    logic [OpWidth-1:0] op;
    logic [NodeWidth-1:0] node;
    int unsigned roll;
    int unsigned insert_pct;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    calm = 1'b0;
    mode = MIX_FILL;
    dq_head = NO_LINK;
    dq_tail = NO_LINK;
    dq_count = '0;
    for (int i = 0; i < NODES; i++) begin
      dq_next[i] = NO_LINK;
      dq_prev[i] = NO_LINK;
      dq_member[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_request(plan[i].op, plan[i].node, plan[i].typed, plan[i].want);
    drain_results();

    for (int unsigned k = 0; k < RANDOM_REQUESTS; k++) begin
      if (k % BURST_LEN == 0) mode = mix_e'($urandom_range(MIX_FILL, MIX_EVEN));
      calm = (k >= CALM_FIRST) && (k < CALM_LAST);
      if (k == DRAIN_AT) drain_results();
      case (mode)
        MIX_FILL:  insert_pct = 75;
        MIX_DRAIN: insert_pct = 20;
        default:   insert_pct = 45;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        op = $urandom_range(0, 1) ? OP_INS_TAIL : OP_INS_HEAD;
        node = ($urandom_range(0, 3) != 0) ? pick_node(1'b0)
                                           : NodeWidth'($urandom_range(0, NODES - 1));
      end else if (roll < 95) begin
        case ($urandom_range(0, 2))
          0:       op = OP_REM_FRONT;
          1:       op = OP_REM_REAR;
          default: op = OP_REM_NAMED;
        endcase
        node = ($urandom_range(0, 3) != 0) ? pick_node(1'b1)
                                           : NodeWidth'($urandom_range(0, NODES - 1));
      end else begin
        op = OpWidth'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        node = NodeWidth'($urandom_range(0, NODES - 1));
      end
      send_request(op, node, 1'b0, '0);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ddm_pkg.sv
design/ddm_ctrl.sv
design/ddm_datapath.sv
design/doubly_linked_deque_manager.sv
tb/tb_top.sv
